// ----- rtl/size_class_pool_allocator_core_defines.svh -----
// assertion macros for the checker file
`ifndef SIZE_CLASS_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define SIZE_CLASS_POOL_ALLOCATOR_CORE_DEFINES_SVH

// clocked assertion with asynchronous active-low reset
`define SCPA_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("size class pool allocator assertion failed");

// shorthand for the default clock and reset names
`define SCPA_ASSERT(lbl, prop) `SCPA_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

// ----- rtl/scpa_pkg.sv -----
// package with field widths and command and status codes of the allocator
`timescale 1ns / 1ps
package scpa_pkg;
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned ADDR_W   = 30;
  localparam int unsigned WORDS_W  = 20;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned TOTAL_W  = 9;

  typedef enum logic [CMD_W-1:0] {
    CMD_FORMAT = 2'd0,
    CMD_ALLOC  = 2'd1,
    CMD_FREE   = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_ZERO_SIZE = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_FREE   = 3'd3,
    ST_NOT_ALLOC = 3'd4
  } status_e;
endpackage

// ----- rtl/scpa_alu.sv -----
// shared subtract and compare unit used by carving and class search
`timescale 1ns / 1ps
module scpa_alu (
  input  logic [scpa_pkg::WORDS_W:0] a_i,
  input  logic [scpa_pkg::WORDS_W:0] b_i,
  output logic [scpa_pkg::WORDS_W:0] diff_o,
  output logic                       lt_o
);
  logic [scpa_pkg::WORDS_W+1:0] full;

  // borrow out of the subtract gives a < b
  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[scpa_pkg::WORDS_W:0];
  assign lt_o   = full[scpa_pkg::WORDS_W+1];
endmodule

// ----- rtl/scpa_mem.sv -----
// block descriptor store: list link, payload address, class and allocated flag per block
`timescale 1ns / 1ps
module scpa_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned IDX_W = 8,
  parameter int unsigned CLS_W = 3
) (
  input  logic                        clk_i,
  input  logic                        we_next_i,
  input  logic                        we_info_i,
  input  logic                        we_use_i,
  input  logic [IDX_W-1:0]            waddr_i,
  input  logic [IDX_W-1:0]            wnext_i,
  input  logic [scpa_pkg::ADDR_W-1:0] wstart_i,
  input  logic [CLS_W-1:0]            wclass_i,
  input  logic                        wuse_i,
  input  logic [IDX_W-1:0]            raddr_i,
  output logic [IDX_W-1:0]            rnext_o,
  output logic [scpa_pkg::ADDR_W-1:0] rstart_o,
  output logic [CLS_W-1:0]            rclass_o,
  output logic                        ruse_o
);
  logic [IDX_W-1:0]            next_mem  [DEPTH];
  logic [scpa_pkg::ADDR_W-1:0] start_mem [DEPTH];
  logic [CLS_W-1:0]            class_mem [DEPTH];
  logic                        use_mem   [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_next_i) begin
      next_mem[waddr_i] <= wnext_i;
    end
    if (we_info_i) begin
      start_mem[waddr_i] <= wstart_i;
      class_mem[waddr_i] <= wclass_i;
    end
    if (we_use_i) begin
      use_mem[waddr_i] <= wuse_i;
    end
    rnext_o  <= next_mem[raddr_i];
    rstart_o <= start_mem[raddr_i];
    rclass_o <= class_mem[raddr_i];
    ruse_o   <= use_mem[raddr_i];
  end
endmodule

// ----- rtl/size_class_pool_allocator_core.sv -----
// top level of the power-of-two size class pool allocator
//
// channels: s_axis carries one command (format, allocate, free) per transfer,
// m_axis returns one result per command, cfg writes region_base (index 0)
// and region_words (index 1); config is to be written only while the block
// is idle, and the block itself does not enforce this. one command is in
// work at a time; s_axis_tready is high only when idle.
// steps from accept to result register:
//   format:   carves one block per class in turn and skips each class that does
//             not fit in what is left, until the region is used up, MAX_BLOCKS
//             blocks exist or NUM_CLASSES classes have been skipped
//   allocate: fit search tries classes from the smallest up, then free search
//             goes on from the fitting class, then a pop when a block is found
//   free:     scans descriptors in turn, each a registered store read and a compare
// the registered store read port and the one shared compare unit shape these steps.
// the result sits in an output register; a new command is accepted while it
// waits, and a second result waits in the sequencer until m_axis_tready.
// reset empties all free lists and clears the block count; descriptor entries
// and allocated flags hold no reset, and format writes each carved entry
// with a clear flag before any read of it.
`timescale 1ns / 1ps
module size_class_pool_allocator_core #(
  parameter int unsigned NUM_CLASSES    = 5,
  parameter int unsigned MIN_CLASS_LOG2 = 4,
  parameter int unsigned MAX_BLOCKS     = 256,
  parameter int unsigned HEADER_WORDS   = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cmd[1:0], size_words[21:2], address[51:22], zero fill
  input  logic [55:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // status[2:0], block_address[32:3], block_words[52:33], blocks_made[61:53]
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [29:0] cfg_data_i
);
  localparam int unsigned IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int unsigned TOT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned SKP_W = $clog2(NUM_CLASSES + 1);
  localparam int unsigned AW    = scpa_pkg::ADDR_W;
  localparam int unsigned WW    = scpa_pkg::WORDS_W;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CARVE = 9'b000000010,
    S_FIT   = 9'b000000100,
    S_SRCH  = 9'b000001000,
    S_POP   = 9'b000010000,
    S_RRD   = 9'b000100000,
    S_RCMP  = 9'b001000000,
    S_DONE  = 9'b010000000,
    S_HOLD  = 9'b100000000
  } state_e;

  function automatic logic [WW-1:0] cls_words(input logic [CLS_W-1:0] c);
    cls_words = WW'(1) << (MIN_CLASS_LOG2 + c);
  endfunction

  state_e state_q, state_d;

  logic [AW-1:0] base_q;
  logic [WW-1:0] rwords_q;

  logic [IDX_W-1:0] head_q  [NUM_CLASSES];
  logic [IDX_W-1:0] head_d  [NUM_CLASSES];
  logic [TOT_W-1:0] count_q [NUM_CLASSES];
  logic [TOT_W-1:0] count_d [NUM_CLASSES];
  logic [TOT_W-1:0] total_q, total_d;

  logic [AW-1:0]    pos_q, pos_d;
  logic [WW-1:0]    left_q, left_d;
  logic [CLS_W-1:0] cls_q, cls_d;
  logic [SKP_W-1:0] skips_q, skips_d;
  logic [TOT_W-1:0] idx_q, idx_d;
  logic [WW-1:0]    size_q, size_d;
  logic [AW-1:0]    addr_q, addr_d;

  logic [scpa_pkg::STATUS_W-1:0] res_st_q, res_st_d;
  logic [AW-1:0] res_addr_q, res_addr_d;
  logic [WW-1:0] res_words_q, res_words_d;

  logic        out_valid_q;
  logic [63:0] out_data_q;
  logic        load_out;

  // shared unit
  logic [WW:0] alu_a, alu_b, alu_diff;
  logic        alu_lt;

  // descriptor store
  logic             we_next, we_info, we_use;
  logic [IDX_W-1:0] waddr, wnext, raddr_d, raddr_q;
  logic [AW-1:0]    wstart, rstart;
  logic [CLS_W-1:0] wclass, rclass;
  logic             wuse, ruse;
  logic [IDX_W-1:0] rnext;

  logic [scpa_pkg::CMD_W-1:0] in_cmd;
  logic [WW-1:0] in_size;
  logic [AW-1:0] in_addr;
  logic [WW:0]   need;
  logic          odd;

  assign in_cmd  = s_axis_tdata[1:0];
  assign in_size = s_axis_tdata[21:2];
  assign in_addr = s_axis_tdata[51:22];

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign need = (WW+1)'(HEADER_WORDS) + {1'b0, cls_words(cls_q)};
  assign odd  = base_q[0] ^ HEADER_WORDS[0];

  scpa_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .lt_o   (alu_lt)
  );

  scpa_mem #(
    .DEPTH (MAX_BLOCKS),
    .IDX_W (IDX_W),
    .CLS_W (CLS_W)
  ) u_mem (
    .clk_i     (clk_i),
    .we_next_i (we_next),
    .we_info_i (we_info),
    .we_use_i  (we_use),
    .waddr_i   (waddr),
    .wnext_i   (wnext),
    .wstart_i  (wstart),
    .wclass_i  (wclass),
    .wuse_i    (wuse),
    .raddr_i   (raddr_d),
    .rnext_o   (rnext),
    .rstart_o  (rstart),
    .rclass_o  (rclass),
    .ruse_o    (ruse)
  );

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    total_d     = total_q;
    pos_d       = pos_q;
    left_d      = left_q;
    cls_d       = cls_q;
    skips_d     = skips_q;
    idx_d       = idx_q;
    size_d      = size_q;
    addr_d      = addr_q;
    res_st_d    = res_st_q;
    res_addr_d  = res_addr_q;
    res_words_d = res_words_q;
    raddr_d     = raddr_q;
    alu_a       = {1'b0, left_q};
    alu_b       = need;
    we_next     = 1'b0;
    we_info     = 1'b0;
    we_use      = 1'b0;
    waddr       = total_q[IDX_W-1:0];
    wnext       = head_q[cls_q];
    wstart      = pos_q + AW'(HEADER_WORDS);
    wclass      = cls_q;
    wuse        = 1'b0;
    load_out    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          size_d      = in_size;
          addr_d      = in_addr;
          cls_d       = '0;
          idx_d       = '0;
          res_st_d    = scpa_pkg::ST_OK;
          res_addr_d  = '0;
          res_words_d = '0;
          case (in_cmd)
            scpa_pkg::CMD_FORMAT: begin
              for (int c = 0; c < NUM_CLASSES; c++) begin
                count_d[c] = '0;
              end
              total_d  = '0;
              skips_d  = '0;
              pos_d    = base_q + AW'(odd);
              left_d   = (odd && rwords_q != '0) ? rwords_q - WW'(1) : rwords_q;
              state_d  = S_CARVE;
            end
            scpa_pkg::CMD_ALLOC: begin
              if (in_size == '0) begin
                res_st_d = scpa_pkg::ST_ZERO_SIZE;
                state_d  = S_DONE;
              end else begin
                state_d = S_FIT;
              end
            end
            scpa_pkg::CMD_FREE: state_d = S_RRD;
            default:            state_d = S_DONE;
          endcase
        end
      end
      S_CARVE: begin
        if (left_q == '0 || total_q == TOT_W'(MAX_BLOCKS)) begin
          state_d = S_DONE;
        end else if (alu_lt) begin
          // class does not fit in what is left
          skips_d = skips_q + SKP_W'(1);
          if (skips_q == SKP_W'(NUM_CLASSES - 1)) begin
            state_d = S_DONE;
          end
          cls_d = (cls_q == CLS_W'(NUM_CLASSES - 1)) ? '0 : cls_q + CLS_W'(1);
        end else begin
          // new block starts out free
          we_next           = 1'b1;
          we_info           = 1'b1;
          we_use            = 1'b1;
          head_d[cls_q]     = total_q[IDX_W-1:0];
          count_d[cls_q]    = count_q[cls_q] + TOT_W'(1);
          total_d           = total_q + TOT_W'(1);
          pos_d             = pos_q + AW'(need);
          left_d            = alu_diff[WW-1:0];
          cls_d = (cls_q == CLS_W'(NUM_CLASSES - 1)) ? '0 : cls_q + CLS_W'(1);
        end
      end
      S_FIT: begin
        alu_a = {1'b0, cls_words(cls_q)};
        alu_b = {1'b0, size_q};
        if (alu_lt) begin
          if (cls_q == CLS_W'(NUM_CLASSES - 1)) begin
            res_st_d = scpa_pkg::ST_TOO_LARGE;
            state_d  = S_DONE;
          end else begin
            cls_d = cls_q + CLS_W'(1);
          end
        end else begin
          state_d = S_SRCH;
        end
      end
      S_SRCH: begin
        if (count_q[cls_q] != '0) begin
          raddr_d = head_q[cls_q];
          state_d = S_POP;
        end else if (cls_q == CLS_W'(NUM_CLASSES - 1)) begin
          res_st_d = scpa_pkg::ST_NO_FREE;
          state_d  = S_DONE;
        end else begin
          cls_d = cls_q + CLS_W'(1);
        end
      end
      S_POP: begin
        head_d[cls_q]     = rnext;
        count_d[cls_q]    = count_q[cls_q] - TOT_W'(1);
        we_use            = 1'b1;
        waddr             = raddr_q;
        wuse              = 1'b1;
        res_addr_d        = rstart;
        res_words_d       = cls_words(cls_q);
        state_d           = S_DONE;
      end
      S_RRD: begin
        if (idx_q >= total_q) begin
          res_st_d = scpa_pkg::ST_NOT_ALLOC;
          state_d  = S_DONE;
        end else begin
          raddr_d = idx_q[IDX_W-1:0];
          state_d = S_RCMP;
        end
      end
      S_RCMP: begin
        if (ruse && rstart == addr_q) begin
          we_next           = 1'b1;
          we_use            = 1'b1;
          waddr             = raddr_q;
          wnext             = head_q[rclass];
          head_d[rclass]    = raddr_q;
          count_d[rclass]   = count_q[rclass] + TOT_W'(1);
          res_addr_d        = addr_q;
          res_words_d       = cls_words(rclass);
          state_d           = S_DONE;
        end else begin
          idx_d   = idx_q + TOT_W'(1);
          state_d = S_RRD;
        end
      end
      S_DONE, S_HOLD: begin
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end else begin
          state_d = S_HOLD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      base_q      <= '0;
      rwords_q    <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        count_q[c] <= '0;
        head_q[c]  <= '0;
      end
    end else begin
      state_q  <= state_d;
      total_q  <= total_d;
      count_q  <= count_d;
      head_q   <= head_d;
      if (cfg_valid_i) begin
        if (cfg_index_i) begin
          rwords_q <= cfg_data_i[WW-1:0];
        end else begin
          base_q <= cfg_data_i;
        end
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q       <= pos_d;
    left_q      <= left_d;
    cls_q       <= cls_d;
    skips_q     <= skips_d;
    idx_q       <= idx_d;
    size_q      <= size_d;
    addr_q      <= addr_d;
    res_st_q    <= res_st_d;
    res_addr_q  <= res_addr_d;
    res_words_q <= res_words_d;
    raddr_q     <= raddr_d;
    if (load_out) begin
      out_data_q <= {2'b00, scpa_pkg::TOTAL_W'(total_q), res_words_q, res_addr_q, res_st_q};
    end
  end
endmodule

// ----- rtl/scpa_checker.sv -----
// port-level checker for the allocator top level, bound to it below
`timescale 1ns / 1ps
`include "size_class_pool_allocator_core_defines.svh"
module scpa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [63:0] m_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready
);
  logic [scpa_pkg::STATUS_W-1:0] st;
  logic [scpa_pkg::ADDR_W-1:0]   baddr;
  logic [scpa_pkg::WORDS_W-1:0]  bwords;

  assign st     = m_axis_tdata[2:0];
  assign baddr  = m_axis_tdata[32:3];
  assign bwords = m_axis_tdata[52:33];

  // one command at a time
  `SCPA_ASSERT(a_busy_after_accept, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  `SCPA_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
  `SCPA_ASSERT(a_status_range, m_axis_tvalid |-> st <= scpa_pkg::ST_NOT_ALLOC)
  `SCPA_ASSERT(a_fail_zero, m_axis_tvalid && st != scpa_pkg::ST_OK |-> baddr == '0 && bwords == '0)
  // granted or freed sizes are powers of two
  `SCPA_ASSERT(a_pow2, m_axis_tvalid && bwords != '0 |-> $onehot(bwords))
endmodule

bind size_class_pool_allocator_core scpa_checker u_scpa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
